// ----- hdl/iemgb_pkg.sv -----
// ----------------------------------------------------------------------------
// iemgb_pkg
// Shared types, constants and the event judge function for the interval
// event merger with gap bridging.
// ----------------------------------------------------------------------------
package iemgb_pkg;

	localparam int POS_W   = 31;
	localparam int DEPTH_W = 16;
	localparam int GAP_W   = 16;

	localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};
	localparam logic [GAP_W-1:0]   GAP_RESET = GAP_W'(100);

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_END   = 1'b1;

	// state carried from one judged event to the next
	typedef struct packed {
		logic [POS_W-1:0]   before_pos;
		logic               before_kind;
		logic               before_valid;
		logic [DEPTH_W-1:0] depth;
		logic               skip;
	} judge_st_t;

	typedef struct packed {
		judge_st_t st;
		logic      emit;
		logic      kind;
	} judge_res_t;

	// one result item
	typedef struct packed {
		logic             has;
		logic [POS_W-1:0] pos;
		logic             kind;
		logic             done;
	} result_t;

	// results pushed into the output queue for one request
	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} push_t;

	// judge one event against its lookahead and the event before it
	function automatic judge_res_t judge_event(
		input judge_st_t        st,
		input logic [POS_W-1:0] pos,
		input logic             kind,
		input logic             nxt_valid,
		input logic [POS_W-1:0] nxt_pos,
		input logic             nxt_kind,
		input logic [GAP_W-1:0] gap
	);
		judge_res_t       r;
		logic [POS_W-1:0] span;
		r      = '0;
		r.st   = st;
		r.kind = kind;
		span   = (nxt_pos >= pos) ? (nxt_pos - pos) : (pos - nxt_pos);
		// merged start, unless it is a zero-length interval
		if (kind == KIND_START && st.depth == '0 &&
			!(nxt_valid && nxt_kind == KIND_END && nxt_pos == pos)) begin
			if (!st.skip) begin
				r.emit = 1'b1;
			end else begin
				r.st.skip = 1'b0;
			end
		end
		// merged end, bridged when the next start is close
		if (kind == KIND_END && st.depth == DEPTH_W'(1) &&
			!(st.before_valid && st.before_kind == KIND_START &&
			  st.before_pos == pos)) begin
			if (nxt_valid && nxt_kind == KIND_START && span < POS_W'(gap)) begin
				r.st.skip = 1'b1;
			end
			if (!r.st.skip) begin
				r.emit = 1'b1;
			end
		end
		// saturating nesting depth
		if (kind == KIND_START) begin
			if (st.depth != DEPTH_MAX) begin
				r.st.depth = st.depth + DEPTH_W'(1);
			end
		end else begin
			if (st.depth != '0) begin
				r.st.depth = st.depth - DEPTH_W'(1);
			end
		end
		r.st.before_pos   = pos;
		r.st.before_kind  = kind;
		r.st.before_valid = 1'b1;
		return r;
	endfunction

endpackage

// ----- hdl/interval_event_merge_gap_bridge_core.sv -----
// ----------------------------------------------------------------------------
// interval_event_merge_gap_bridge_core
// Merges a sorted stream of interval start/end events into the boundaries
// of their union, dropping zero-length intervals and bridging short gaps.
// ----------------------------------------------------------------------------
//  channel | signals                                   | role
//  --------+-------------------------------------------+------------------
//  in      | in_valid/in_ready, event_position/kind,   | event requests
//          | is_last                                   |
//  out     | out_valid/out_ready, has_boundary,        | result requests
//          | boundary_position/kind, list_done         |
//  cfg     | cfg_we, cfg_wdata                         | gap_limit write
//
// One event per cycle is accepted while the queue has room; a request is
// registered, judged once the queue has room for two results, and its
// results land in a four-entry output queue.
// A last event may give two results; the queue drains them one a cycle while out_ready is high.
// in_ready drops while the input register is held for lack of queue room.
// Reset clears all list state and sets gap_limit to 100.
// ----------------------------------------------------------------------------
module interval_event_merge_gap_bridge_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [iemgb_pkg::GAP_W-1:0] cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [iemgb_pkg::POS_W-1:0] event_position,
	input  logic                        event_kind,
	input  logic                        is_last,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        has_boundary,
	output logic [iemgb_pkg::POS_W-1:0] boundary_position,
	output logic                        boundary_kind,
	output logic                        list_done
);
	import iemgb_pkg::*;

	logic [GAP_W-1:0] gap_limit_q;
	logic             valid_s1;
	logic [POS_W-1:0] pos_s1;
	logic             kind_s1;
	logic             last_s1;
	logic             step;
	logic             room2;
	push_t            push;
	result_t          head;

	assign step     = valid_s1 && room2;
	assign in_ready = !valid_s1 || step;

	// gap limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit_q <= GAP_RESET;
		end else if (cfg_we) begin
			gap_limit_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pos_s1  <= event_position;
			kind_s1 <= event_kind;
			last_s1 <= is_last;
		end
	end

	iemgb_judge u_judge (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.pos    (pos_s1),
		.kind   (kind_s1),
		.last   (last_s1),
		.gap    (gap_limit_q),
		.push   (push)
	);

	iemgb_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (step),
		.push      (push),
		.pop       (out_ready),
		.not_empty (out_valid),
		.room2     (room2),
		.head      (head)
	);

	assign has_boundary      = head.has;
	assign boundary_position = head.pos;
	assign boundary_kind     = head.kind;
	assign list_done         = head.done;

endmodule

// ----- hdl/iemgb_judge.sv -----
// ----------------------------------------------------------------------------
// iemgb_judge
// Holds the lookahead event and merge state; judges the held event per step,
// and the last event as well, and produces up to two result items.
// ----------------------------------------------------------------------------
module iemgb_judge (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  logic [iemgb_pkg::POS_W-1:0] pos,
	input  logic                      kind,
	input  logic                      last,
	input  logic [iemgb_pkg::GAP_W-1:0] gap,
	output iemgb_pkg::push_t          push
);
	import iemgb_pkg::*;

	logic [POS_W-1:0] held_pos_q;
	logic             held_kind_q;
	logic             held_valid_q;
	judge_st_t        st_q;

	judge_res_t j0;
	judge_res_t j1;
	logic       e0;
	logic       e1;
	result_t    rh;
	result_t    rc;

	// held event against the new one, then the last event with no lookahead
	always_comb begin
		j0 = judge_event(st_q, held_pos_q, held_kind_q, 1'b1, pos, kind, gap);
		j1 = judge_event(j0.st, pos, kind, 1'b0, '0, KIND_START, gap);
		e0 = held_valid_q && j0.emit;
		e1 = held_valid_q && last && j1.emit;
	end

	// assemble results
	always_comb begin
		rh      = '{has: 1'b1, pos: held_pos_q, kind: j0.kind, done: 1'b0};
		rc      = '{has: 1'b1, pos: pos, kind: j1.kind, done: 1'b1};
		push    = '0;
		push.r0 = rh;
		push.r1 = rc;
		if (!last) begin
			push.cnt = {1'b0, e0};
		end else if (e0 && e1) begin
			push.cnt = 2'd2;
		end else if (e0) begin
			push.cnt     = 2'd1;
			push.r0.done = 1'b1;
		end else if (e1) begin
			push.cnt = 2'd1;
			push.r0  = rc;
		end else begin
			// bare end marker
			push.cnt = 2'd1;
			push.r0  = '{has: 1'b0, pos: '0, kind: KIND_START, done: 1'b1};
		end
	end

	// state update, cleared after each list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_pos_q   <= '0;
			held_kind_q  <= 1'b0;
			held_valid_q <= 1'b0;
			st_q         <= '0;
		end else if (step) begin
			if (last) begin
				held_pos_q   <= '0;
				held_kind_q  <= 1'b0;
				held_valid_q <= 1'b0;
				st_q         <= '0;
			end else begin
				held_pos_q   <= pos;
				held_kind_q  <= kind;
				held_valid_q <= 1'b1;
				if (held_valid_q) begin
					st_q <= j0.st;
				end
			end
		end
	end

endmodule

// ----- hdl/iemgb_out_fifo.sv -----
// ----------------------------------------------------------------------------
// iemgb_out_fifo
// Four-entry result queue: takes up to two results per cycle, hands out one when pop is set.
// ----------------------------------------------------------------------------
module iemgb_out_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_en,
	input  iemgb_pkg::push_t    push,
	input  logic                pop,
	output logic                not_empty,
	output logic                room2,
	output iemgb_pkg::result_t  head
);
	import iemgb_pkg::*;

	result_t    ent_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;
	logic [1:0] n_push;
	logic       do_pop;

	assign not_empty = cnt_q != 3'd0;
	assign room2     = cnt_q <= 3'd2;
	assign head      = ent_q[rd_q];
	assign do_pop    = pop && not_empty;
	assign n_push    = push_en ? push.cnt : 2'd0;

	// entry storage
	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			ent_q[wr_q] <= push.r0;
		end
		if (n_push == 2'd2) begin
			ent_q[wr_q + 2'd1] <= push.r1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + n_push;
			rd_q  <= rd_q + {1'b0, do_pop};
			cnt_q <= cnt_q + {1'b0, n_push} - {2'b0, do_pop};
		end
	end

endmodule
